>>> src/fqws_pkg.sv
// ----------------------------------------------------------------------------
// fqws_pkg: shared types and constants of the face quality score block
// Widths, fixed point constants and the small tables of the score pipeline.
// ----------------------------------------------------------------------------
package fqws_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_MIN  = 3'd0,
    REG_SIZE_MAX  = 3'd1,
    REG_SIZE_KNEE = 3'd2,
    REG_FRONT_THR = 3'd3,
    REG_SIZE_GAIN = 3'd4,
    REG_POSE_GAIN = 3'd5,
    REG_LMK_GAIN  = 3'd6,
    REG_BLUR_GAIN = 3'd7
  } cfg_reg_t;

  localparam int POINT_DIVISOR = 5;
  localparam int SUM_W = 16;
  localparam int LMK_SHIFT = 32;
  localparam logic [63:0] LMK_MUL64 =
    ((64'd1 << LMK_SHIFT) + 64'(POINT_DIVISOR) - 64'd1) / 64'(POINT_DIVISOR);
  localparam logic [32:0] LMK_MUL = LMK_MUL64[32:0];

  localparam int P9_SHIFT = 25;
  localparam logic [21:0] P9_MUL = 22'd3728271;

  localparam int DIV_NW = 24;
  localparam int DIV_DW = 12;

  localparam logic [12:0] ONE_Q12 = 13'd4096;
  localparam logic [12:0] HALF_Q12 = 13'd2048;
  localparam logic signed [11:0] ANGLE_LIM = 12'sd1440;
  localparam logic signed [27:0] FRONT_MAX = 28'sd8192000;
  localparam logic signed [27:0] FRONT_MIN = -28'sd8187904;
  localparam logic signed [12:0] FRONT_FULL = 13'sd2000;
  localparam logic signed [30:0] OUT_MAX = 31'sd1048575;
  localparam logic signed [30:0] OUT_MIN = -31'sd1048576;

  typedef enum logic [1:0] {
    SZ_ZERO,
    SZ_ONE,
    SZ_UPPER,
    SZ_LOWER
  } size_sel_t;

  typedef struct packed {
    size_sel_t  sel;
    logic       pose_neg;
    logic       den_zero;
    logic [12:0] lmk;
    logic [12:0] blur;
    logic       hq;
  } side_t;

  function automatic logic [7:0] frac160(input logic [3:0] b);
    logic [7:0] r;
    case (b)
      4'd0: r = 8'd0;
      4'd1: r = 8'd17;
      4'd2: r = 8'd35;
      4'd3: r = 8'd53;
      4'd4: r = 8'd71;
      4'd5: r = 8'd88;
      4'd6: r = 8'd106;
      4'd7: r = 8'd124;
      4'd8: r = 8'd142;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/fqws_div.sv
// ----------------------------------------------------------------------------
// fqws_div: pipelined unsigned restoring divider
// One quotient bit per stage; a new division can enter in every enabled cycle.
// ----------------------------------------------------------------------------
module fqws_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [fqws_pkg::DIV_NW-1:0]   num,
  input  logic [fqws_pkg::DIV_DW-1:0]   den,
  output logic [fqws_pkg::DIV_NW-1:0]   quo
);

  logic [fqws_pkg::DIV_DW-1:0] rem_q [fqws_pkg::DIV_NW];
  logic [fqws_pkg::DIV_NW-1:0] num_q [fqws_pkg::DIV_NW];
  logic [fqws_pkg::DIV_DW-1:0] den_q [fqws_pkg::DIV_NW];
  logic [fqws_pkg::DIV_NW-1:0] quo_q [fqws_pkg::DIV_NW];

  logic [fqws_pkg::DIV_DW-1:0] rem_in [fqws_pkg::DIV_NW];
  logic [fqws_pkg::DIV_NW-1:0] num_in [fqws_pkg::DIV_NW];
  logic [fqws_pkg::DIV_DW-1:0] den_in [fqws_pkg::DIV_NW];
  logic [fqws_pkg::DIV_NW-1:0] quo_in [fqws_pkg::DIV_NW];

  logic [fqws_pkg::DIV_DW-1:0] rem_next [fqws_pkg::DIV_NW];
  logic                        bit_next [fqws_pkg::DIV_NW];

  always_comb begin
    rem_in[0] = '0;
    num_in[0] = num;
    den_in[0] = den;
    quo_in[0] = '0;
    for (int i = 1; i < fqws_pkg::DIV_NW; i++) begin
      rem_in[i] = rem_q[i-1];
      num_in[i] = num_q[i-1];
      den_in[i] = den_q[i-1];
      quo_in[i] = quo_q[i-1];
    end
  end

  always_comb begin
    logic [fqws_pkg::DIV_DW:0] t;
    logic [fqws_pkg::DIV_DW:0] diff;
    for (int i = 0; i < fqws_pkg::DIV_NW; i++) begin
      t = {rem_in[i], num_in[i][fqws_pkg::DIV_NW-1]};
      diff = t - {1'b0, den_in[i]};
      bit_next[i] = (t >= {1'b0, den_in[i]});
      rem_next[i] = bit_next[i] ? diff[fqws_pkg::DIV_DW-1:0] : t[fqws_pkg::DIV_DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < fqws_pkg::DIV_NW; i++) begin
        rem_q[i] <= rem_next[i];
        num_q[i] <= {num_in[i][fqws_pkg::DIV_NW-2:0], 1'b0};
        den_q[i] <= den_in[i];
        quo_q[i] <= {quo_in[i][fqws_pkg::DIV_NW-2:0], bit_next[i]};
      end
    end
  end

  assign quo = quo_q[fqws_pkg::DIV_NW-1];

endmodule

>>> src/face_quality_weighted_score.sv
// ----------------------------------------------------------------------------
// face_quality_weighted_score: weighted quality score of one detected face
// Size, pose, landmark and quality terms, weighted and summed in Q.12.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  input    | in        | in_valid / in_ready    | box, angles, point scores, blur
//  output   | out       | out_valid / out_ready  | face_score
//  config   | in        | cfg_write              | cfg_index, cfg_data
//
// One beat is accepted per cycle while the output is not stalled; a result
// passes through 29 register stages: three front stages, the
// 24 stages of the pipelined dividers, the product stage and the output.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module face_quality_weighted_score (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [11:0]                         box_width,
  input  logic [11:0]                         box_height,
  input  logic signed [11:0]                  yaw_angle,
  input  logic signed [11:0]                  pitch_angle,
  input  logic [12:0]                         point_score_0,
  input  logic [12:0]                         point_score_1,
  input  logic [12:0]                         point_score_2,
  input  logic [12:0]                         point_score_3,
  input  logic [12:0]                         point_score_4,
  input  logic signed [13:0]                  blur_value,
  input  logic                                has_quality,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [20:0]                  face_score,
  input  logic                                cfg_write,
  input  logic [fqws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fqws_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [11:0] size_lo, size_hi, size_knee;
  logic signed [11:0] front_thr;
  logic [15:0] size_gain, pose_gain, lmk_gain, blur_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_lo   <= 12'd40;
      size_hi   <= 12'd200;
      size_knee <= 12'd80;
      front_thr <= '0;
      size_gain <= 16'd1024;
      pose_gain <= 16'd1024;
      lmk_gain  <= 16'd1024;
      blur_gain <= 16'd1024;
    end else if (cfg_write) begin
      case (fqws_pkg::cfg_reg_t'(cfg_index))
        fqws_pkg::REG_SIZE_MIN:  size_lo   <= cfg_data[11:0];
        fqws_pkg::REG_SIZE_MAX:  size_hi   <= cfg_data[11:0];
        fqws_pkg::REG_SIZE_KNEE: size_knee <= cfg_data[11:0];
        fqws_pkg::REG_FRONT_THR: front_thr <= $signed(cfg_data[11:0]);
        fqws_pkg::REG_SIZE_GAIN: size_gain <= cfg_data;
        fqws_pkg::REG_POSE_GAIN: pose_gain <= cfg_data;
        fqws_pkg::REG_LMK_GAIN:  lmk_gain  <= cfg_data;
        fqws_pkg::REG_BLUR_GAIN: blur_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: size selection, angle clamp and squares, landmark sum.
  logic [11:0] s_min;
  fqws_pkg::size_sel_t sel1_next;
  logic [11:0] x1_next, d1_next;
  logic signed [11:0] yc, pc;
  logic signed [23:0] ysq_full, psq_full;
  logic [12:0] blur1_next;

  always_comb begin
    s_min = (box_width < box_height) ? box_width : box_height;
    sel1_next = fqws_pkg::SZ_ZERO;
    x1_next = '0;
    d1_next = '0;
    if (s_min < size_lo) begin
      sel1_next = fqws_pkg::SZ_ZERO;
    end else if (s_min > size_hi) begin
      sel1_next = fqws_pkg::SZ_ONE;
    end else if (s_min > size_knee) begin
      sel1_next = fqws_pkg::SZ_UPPER;
      x1_next = s_min - size_knee;
      d1_next = size_hi - size_knee;
    end else if (size_knee <= size_lo) begin
      sel1_next = fqws_pkg::SZ_ZERO;
    end else begin
      sel1_next = fqws_pkg::SZ_LOWER;
      x1_next = s_min - size_lo;
      d1_next = size_knee - size_lo;
    end
    yc = (yaw_angle > fqws_pkg::ANGLE_LIM) ? fqws_pkg::ANGLE_LIM :
         (yaw_angle < -fqws_pkg::ANGLE_LIM) ? -fqws_pkg::ANGLE_LIM : yaw_angle;
    pc = (pitch_angle > fqws_pkg::ANGLE_LIM) ? fqws_pkg::ANGLE_LIM :
         (pitch_angle < -fqws_pkg::ANGLE_LIM) ? -fqws_pkg::ANGLE_LIM : pitch_angle;
    ysq_full = yc * yc;
    psq_full = pc * pc;
    if (blur_value < 14'sd0) begin
      blur1_next = '0;
    end else if (blur_value > $signed({1'b0, fqws_pkg::ONE_Q12})) begin
      blur1_next = fqws_pkg::ONE_Q12;
    end else begin
      blur1_next = blur_value[12:0];
    end
  end

  logic v1;
  fqws_pkg::size_sel_t sel1;
  logic [11:0] x1, d1;
  logic [21:0] ysq1;
  logic [20:0] psq1;
  logic [fqws_pkg::SUM_W-1:0] lsum1;
  logic [12:0] blur1;
  logic hq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel1  <= sel1_next;
      x1    <= x1_next;
      d1    <= d1_next;
      ysq1  <= ysq_full[21:0];
      psq1  <= psq_full[20:0];
      lsum1 <= fqws_pkg::SUM_W'(point_score_0) + fqws_pkg::SUM_W'(point_score_1)
             + fqws_pkg::SUM_W'(point_score_2) + fqws_pkg::SUM_W'(point_score_3)
             + fqws_pkg::SUM_W'(point_score_4);
      blur1 <= blur1_next;
      hq1   <= has_quality;
    end
  end

  // Stage 2: yaw product, pitch divided by nine, landmark divide.
  logic [42:0] p9_prod;
  logic [fqws_pkg::SUM_W+32:0] lmk_prod;
  logic [fqws_pkg::SUM_W-1:0] lmk_q;

  assign p9_prod = 43'(psq1) * 43'(fqws_pkg::P9_MUL);
  assign lmk_prod = (fqws_pkg::SUM_W+33)'(lsum1) * (fqws_pkg::SUM_W+33)'(fqws_pkg::LMK_MUL);
  assign lmk_q = lmk_prod[fqws_pkg::LMK_SHIFT +: fqws_pkg::SUM_W];

  logic v2;
  fqws_pkg::size_sel_t sel2;
  logic [11:0] x2, d2;
  logic [24:0] y10_2;
  logic [17:0] pa2;
  logic [20:0] psq2;
  logic [12:0] lmk2, blur2;
  logic hq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel2  <= sel1;
      x2    <= x1;
      d2    <= d1;
      y10_2 <= 25'(ysq1) * 25'd10;
      pa2   <= p9_prod[fqws_pkg::P9_SHIFT +: 18];
      psq2  <= psq1;
      lmk2  <= (lmk_q > fqws_pkg::SUM_W'(fqws_pkg::ONE_Q12)) ? fqws_pkg::ONE_Q12
                                                             : lmk_q[12:0];
      blur2 <= blur1;
      hq2   <= hq1;
    end
  end

  // Stage 3: frontalness, pose numerator and denominator.
  logic [3:0] p_rem;
  logic signed [27:0] front, front_c, pose_n;
  logic signed [12:0] pose_d;
  logic [23:0] n_mag;
  logic [11:0] d_mag;

  always_comb begin
    p_rem = 4'(psq2 - 21'(pa2) * 21'd9);
    front = fqws_pkg::FRONT_MAX - $signed({3'b0, y10_2})
          - $signed({2'b0, 26'(pa2) * 26'd160})
          - $signed({20'b0, fqws_pkg::frac160(p_rem)});
    front_c = (front > fqws_pkg::FRONT_MAX) ? fqws_pkg::FRONT_MAX :
              (front < fqws_pkg::FRONT_MIN) ? fqws_pkg::FRONT_MIN : front;
    pose_n = front_c - $signed({{4{front_thr[11]}}, front_thr, 12'b0});
    n_mag = pose_n[27] ? 24'(-pose_n) : pose_n[23:0];
    pose_d = fqws_pkg::FRONT_FULL - $signed({front_thr[11], front_thr});
    d_mag = pose_d[12] ? 12'(-pose_d) : pose_d[11:0];
  end

  logic v3;
  logic [fqws_pkg::DIV_NW-1:0] sz_num3, ps_num3;
  logic [fqws_pkg::DIV_DW-1:0] sz_den3, ps_den3;
  fqws_pkg::side_t side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sz_num3 <= {1'b0, x2, 11'b0};
      sz_den3 <= d2;
      ps_num3 <= n_mag;
      ps_den3 <= d_mag;
      side3.sel      <= sel2;
      side3.pose_neg <= pose_n[27] ^ pose_d[12];
      side3.den_zero <= (pose_d == 13'sd0);
      side3.lmk      <= lmk2;
      side3.blur     <= blur2;
      side3.hq       <= hq2;
    end
  end

  // Divider stages.
  logic [fqws_pkg::DIV_NW-1:0] sz_quo, ps_quo;

  fqws_div u_size_div (
    .clk (clk),
    .en  (en),
    .num (sz_num3),
    .den (sz_den3),
    .quo (sz_quo)
  );

  fqws_div u_pose_div (
    .clk (clk),
    .en  (en),
    .num (ps_num3),
    .den (ps_den3),
    .quo (ps_quo)
  );

  fqws_pkg::side_t side_d [fqws_pkg::DIV_NW];
  logic [fqws_pkg::DIV_NW-1:0] v_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= '0;
    end else if (en) begin
      v_d <= {v_d[fqws_pkg::DIV_NW-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side3;
      for (int i = 1; i < fqws_pkg::DIV_NW; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  // Product stage.
  fqws_pkg::side_t sd;
  logic [12:0] size_term;
  logic signed [24:0] pose_term;

  always_comb begin
    sd = side_d[fqws_pkg::DIV_NW-1];
    case (sd.sel)
      fqws_pkg::SZ_ZERO:  size_term = '0;
      fqws_pkg::SZ_ONE:   size_term = fqws_pkg::ONE_Q12;
      fqws_pkg::SZ_UPPER: size_term = fqws_pkg::HALF_Q12 + sz_quo[12:0];
      fqws_pkg::SZ_LOWER: size_term = sz_quo[12:0];
      default:            size_term = '0;
    endcase
    if (sd.den_zero) begin
      pose_term = '0;
    end else if (sd.pose_neg) begin
      pose_term = -$signed({1'b0, ps_quo});
    end else begin
      pose_term = $signed({1'b0, ps_quo});
    end
  end

  logic vp;
  logic [28:0] size_prod, lmk_prod_p, blur_prod;
  logic signed [41:0] pose_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= v_d[fqws_pkg::DIV_NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      size_prod  <= 29'(size_gain) * 29'(size_term);
      pose_prod  <= $signed({1'b0, pose_gain}) * pose_term;
      lmk_prod_p <= 29'(lmk_gain) * 29'(sd.lmk);
      blur_prod  <= sd.hq ? 29'(blur_gain) * 29'(sd.blur) : 29'd0;
    end
  end

  // Sum, floor to Q.12 and saturate.
  logic signed [42:0] acc;
  logic signed [30:0] acc_sh;
  logic signed [20:0] score_next;

  always_comb begin
    acc = 43'(pose_prod) + $signed({14'b0, size_prod})
        + $signed({14'b0, lmk_prod_p}) + $signed({14'b0, blur_prod});
    acc_sh = acc[42:12];
    score_next = (acc_sh > fqws_pkg::OUT_MAX) ? fqws_pkg::OUT_MAX[20:0] :
                 (acc_sh < fqws_pkg::OUT_MIN) ? fqws_pkg::OUT_MIN[20:0] : acc_sh[20:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face_score <= score_next;
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench of the face quality weighted score block
// A directed table of faces, then random faces under several register
// settings and idling phases; every result is checked against a predictor
// or against the expected score of its table row.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [11:0] w;
    logic [11:0] h;
    logic [11:0] yaw;
    logic [11:0] pitch;
    logic [12:0] pts [5];
    logic [13:0] blur;
    logic        hq;
  } face_t;

  typedef struct {
    face_t        f;
    bit           known;
    logic [20:0]  score;
  } face_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [11:0] box_width = 0, box_height = 0;
  logic signed [11:0] yaw_angle = 0, pitch_angle = 0;
  logic [12:0] point_score_0 = 0, point_score_1 = 0, point_score_2 = 0;
  logic [12:0] point_score_3 = 0, point_score_4 = 0;
  logic signed [13:0] blur_value = 0;
  logic has_quality = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [20:0] face_score;
  logic cfg_write = 0;
  logic [fqws_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fqws_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  face_quality_weighted_score dut (.*);

  logic [11:0] r_min, r_max, r_knee, r_thr;
  logic [15:0] g_size, g_pose, g_lmk, g_blur;
  logic [20:0] score_queue [$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [20:0] score_of(face_t f);
    longint s, lo, hi, kn, st, y, p, fr, thr, den, pt, sum, acc, q;
    s = f.w < f.h ? f.w : f.h;
    lo = r_min;
    hi = r_max;
    kn = r_knee;
    if (s < lo) st = 0;
    else if (s > hi) st = 4096;
    else if (s > kn) st = 2048 + (s - kn) * 2048 / (hi - kn);
    else if (kn - lo <= 0) st = 0;
    else st = (s - lo) * 2048 / (kn - lo);
    y = clampl(longint'($signed(f.yaw)), -1440, 1440);
    p = clampl(longint'($signed(f.pitch)), -1440, 1440);
    fr = 2000 * 4096 - 10 * y * y - (160 * p * p) / 9;
    fr = clampl(fr, -1999 * 4096, 2000 * 4096);
    thr = longint'($signed(r_thr));
    den = 2000 - thr;
    pt = den == 0 ? 0 : (fr - thr * 4096) / den;
    sum = 0;
    foreach (f.pts[i]) sum += f.pts[i];
    acc = longint'(g_size) * st + longint'(g_pose) * pt
        + longint'(g_lmk) * clampl(sum / 5, 0, 4096);
    if (f.hq) acc += longint'(g_blur) * clampl(longint'($signed(f.blur)), 0, 4096);
    q = acc / 4096;
    if (acc % 4096 != 0 && acc < 0) q -= 1;
    return 21'(clampl(q, -1048576, 1048575));
  endfunction

  task automatic write_reg(fqws_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      fqws_pkg::REG_SIZE_MIN: r_min = val[11:0];
      fqws_pkg::REG_SIZE_MAX: r_max = val[11:0];
      fqws_pkg::REG_SIZE_KNEE: r_knee = val[11:0];
      fqws_pkg::REG_FRONT_THR: r_thr = val[11:0];
      fqws_pkg::REG_SIZE_GAIN: g_size = val;
      fqws_pkg::REG_POSE_GAIN: g_pose = val;
      fqws_pkg::REG_LMK_GAIN: g_lmk = val;
      fqws_pkg::REG_BLUR_GAIN: g_blur = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [11:0] mn, logic [11:0] mx, logic [11:0] kn,
                          logic [11:0] thr, logic [15:0] gs, logic [15:0] gp,
                          logic [15:0] gl, logic [15:0] gb);
    write_reg(fqws_pkg::REG_SIZE_MIN, 16'(mn));
    write_reg(fqws_pkg::REG_SIZE_MAX, 16'(mx));
    write_reg(fqws_pkg::REG_SIZE_KNEE, 16'(kn));
    write_reg(fqws_pkg::REG_FRONT_THR, 16'(thr));
    write_reg(fqws_pkg::REG_SIZE_GAIN, gs);
    write_reg(fqws_pkg::REG_POSE_GAIN, gp);
    write_reg(fqws_pkg::REG_LMK_GAIN, gl);
    write_reg(fqws_pkg::REG_BLUR_GAIN, gb);
    cfg_write <= 0;
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 0;
    while (score_queue.size() != 0) @(posedge clk);
    while (n < 40) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic send_face(face_t f, bit known, logic [20:0] score);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    box_width <= f.w;
    box_height <= f.h;
    yaw_angle <= f.yaw;
    pitch_angle <= f.pitch;
    point_score_0 <= f.pts[0];
    point_score_1 <= f.pts[1];
    point_score_2 <= f.pts[2];
    point_score_3 <= f.pts[3];
    point_score_4 <= f.pts[4];
    blur_value <= f.blur;
    has_quality <= f.hq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    score_queue.insert(score_queue.size(), known ? score : score_of(f));
  endtask

  function automatic face_t random_face();
    face_t f;
    int mode;
    mode = $urandom_range(3);
    f.w = mode == 0 ? 12'($urandom) : 12'($urandom_range(300));
    f.h = mode == 0 ? 12'($urandom) : 12'($urandom_range(300));
    f.yaw = 12'($urandom);
    f.pitch = 12'($urandom);
    foreach (f.pts[i]) f.pts[i] = mode == 1 ? 13'($urandom) : 13'($urandom_range(4096));
    f.blur = mode == 2 ? 14'($urandom) : 14'($urandom_range(4200));
    f.hq = 1'($urandom);
    return f;
  endfunction

  function automatic face_t mk(int w, int h, int y, int p, int pt, int b, int hq);
    face_t f;
    f.w = 12'(w);
    f.h = 12'(h);
    f.yaw = 12'(y);
    f.pitch = 12'(p);
    foreach (f.pts[i]) f.pts[i] = 13'(pt);
    f.blur = 14'(b);
    f.hq = 1'(hq);
    return f;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (score_queue.size() == 0) begin
          $error("face_score: unexpected beat, actual %0d", face_score);
          errors++;
        end else begin
          if (face_score !== score_queue[0]) begin
            $error("face_score: expected %0d actual %0d",
                   $signed(score_queue[0]), face_score);
            errors++;
          end
          void'(score_queue.pop_front());
        end
      end
      out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end
  end

  initial begin
    face_row_t rows [$];
    face_t f;
    r_min = 40; r_max = 200; r_knee = 80; r_thr = 0;
    g_size = 1024; g_pose = 1024; g_lmk = 1024; g_blur = 1024;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Reset defaults: a frontal face of full size scores one half.
    rows.insert(rows.size(), '{mk(4095, 4095, 0, 0, 0, 0, 0), 1, 21'd2048});
    rows.insert(rows.size(), '{mk(0, 0, 0, 0, 0, 0, 0), 1, 21'd1024});
    rows.insert(rows.size(), '{mk(4095, 4095, 0, 0, 4096, 4096, 1), 1, 21'd4096});
    rows.insert(rows.size(), '{mk(4095, 4095, 0, 0, 8191, 8191, 1), 1, 21'd4096});
    rows.insert(rows.size(), '{mk(4095, 4095, 0, 0, 0, -8192, 1), 1, 21'd2048});
    rows.insert(rows.size(), '{mk(80, 300, 0, 0, 0, 0, 0), 1, 21'd1536});
    rows.insert(rows.size(), '{mk(39, 39, 2047, -2048, 0, 0, 0), 0, 21'd0});
    rows.insert(rows.size(), '{mk(200, 201, -2048, 2047, 0, 0, 0), 0, 21'd0});
    rows.insert(rows.size(), '{mk(120, 150, 1440, 1441, 100, 0, 0), 0, 21'd0});
    rows.insert(rows.size(), '{mk(60, 60, -1440, 700, 5000, 3000, 1), 0, 21'd0});
    foreach (rows[i]) send_face(rows[i].f, rows[i].known, rows[i].score);
    drain();
    // Threshold at 2000, empty lower span, max gains.
    set_regs(12'd100, 12'd50, 12'd100, 12'd2000,
             16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_face(mk(100, 100, 0, 0, 8191, 8191, 1), 0, 21'd0);
    send_face(mk(100, 4095, 2047, 2047, 0, 0, 1), 0, 21'd0);
    send_face(mk(49, 4095, 0, 0, 0, 0, 0), 0, 21'd0);
    drain();
    set_regs(12'd0, 12'd4095, 12'd4095, 12'h800, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_face(mk(4095, 4095, 2047, 2047, 0, 0, 0), 0, 21'd0);
    send_face(mk(0, 0, 0, 0, 0, 0, 0), 0, 21'd0);
    drain();
    set_regs(12'd0, 12'd4095, 12'd4095, 12'd2001, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_face(mk(4095, 4095, 0, 0, 0, 0, 0), 0, 21'd0);
    send_face(mk(3000, 4095, 1440, 1440, 0, 0, 0), 0, 21'd0);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) set_regs(12'd40, 12'd200, 12'd80, 12'd0,
                            16'd1024, 16'd1024, 16'd1024, 16'd1024);
      else set_regs(12'($urandom_range(300)), 12'($urandom_range(400)),
                    12'($urandom_range(300)),
                    ph == 7 ? 12'($urandom) : 12'($urandom_range(3999) - 1999),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 88; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 88; end
        default: begin send_idle = 23; recv_stall = 23; end
      endcase
      for (int k = 0; k < 118; k++) begin
        f = random_face();
        send_face(f, 0, 21'd0);
        if (ph == 3 && k == 50) begin
          in_valid <= 0;
          while (score_queue.size() != 0) @(posedge clk);
        end
      end
      recv_stall = 0;
      drain();
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
